>>> rtl/cubic_hermite_segment_eval_assert.svh
// Assertion macros shared by the cubic Hermite evaluator RTL.
`ifndef CUBIC_HERMITE_SEGMENT_EVAL_ASSERT_SVH
`define CUBIC_HERMITE_SEGMENT_EVAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/che_pkg.sv
// Shared constants, types and register codes of the cubic Hermite evaluator.
package che_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SLOPE_W    = FRAC_BITS + 2;
    localparam int ACC_W      = 64;
    localparam int PART_W     = 32;
    localparam int H_W        = DATA_WIDTH;
    localparam int Q_W        = DATA_WIDTH + FRAC_BITS + 1;
    localparam int U_W        = Q_W + 1;
    localparam int U_HI_W     = U_W - PART_W;
    localparam int ACC_HI_W   = ACC_W - PART_W;
    localparam int P_W        = ACC_W + U_W;
    localparam int RND_W      = P_W + 1 - FRAC_BITS;
    localparam int CPROD_W    = SLOPE_W + H_W;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEG_START   = 3'd0,
        REG_SEG_END     = 3'd1,
        REG_START_VALUE = 3'd2,
        REG_END_VALUE   = 3'd3,
        REG_START_SLOPE = 3'd4,
        REG_END_SLOPE   = 3'd5
    } cfg_reg_t;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [U_W-1:0]   u_t;

    localparam logic [DATA_WIDTH-1:0] SEG_END_RESET = DATA_WIDTH'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0]      LIMIT_MAG     = ACC_W'(1) << (ACC_W - 2);
    localparam acc_t VAL_MAX = ACC_W'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam acc_t VAL_MIN = -VAL_MAX - acc_t'(1);

    // Segment constants derived from the configuration registers.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] s0;
        logic [H_W-1:0]        h;
        logic                  bad;
        acc_t                  a;
        acc_t                  b;
        acc_t                  c;
        acc_t                  x0;
    } coef_t;

    // Data that travels with an item through the multiply stages.
    typedef struct packed {
        logic sat;
        acc_t acc;
        u_t   u;
    } mac_data_t;

endpackage

>>> rtl/che_coef.sv
// Configuration registers and the derived segment coefficients.
module che_coef (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [che_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [che_pkg::DATA_WIDTH-1:0]  cfg_data,
    output che_pkg::coef_t                  coef
);
    import che_pkg::*;

    logic [DATA_WIDTH-1:0] s0_reg;
    logic [DATA_WIDTH-1:0] s1_reg;
    logic [DATA_WIDTH-1:0] x0_reg;
    logic [DATA_WIDTH-1:0] x1_reg;
    logic [SLOPE_W-1:0]    cs_reg;
    logic [SLOPE_W-1:0]    es_reg;

    logic signed [H_W:0]   h_diff;
    logic [H_W-1:0]        h_reg;
    logic                  bad_reg;
    logic [SLOPE_W-1:0]    c_mag;
    logic [SLOPE_W-1:0]    e_mag;
    logic [CPROD_W-1:0]    cprod_reg;
    logic [CPROD_W-1:0]    eprod_reg;
    logic                  cneg_reg;
    logic                  eneg_reg;
    logic [CPROD_W:0]      c_sum;
    logic [CPROD_W:0]      e_sum;
    logic [CPROD_W-FRAC_BITS:0] c_rnd;
    logic [CPROD_W-FRAC_BITS:0] e_rnd;
    acc_t                  c_val_reg;
    acc_t                  e_val_reg;
    acc_t                  a_reg;
    acc_t                  b_reg;
    acc_t                  x0_ext;
    acc_t                  x1_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= SEG_END_RESET;
            x0_reg <= '0;
            x1_reg <= '0;
            cs_reg <= '0;
            es_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SEG_START:   s0_reg <= cfg_data;
                REG_SEG_END:     s1_reg <= cfg_data;
                REG_START_VALUE: x0_reg <= cfg_data;
                REG_END_VALUE:   x1_reg <= cfg_data;
                REG_START_SLOPE: cs_reg <= cfg_data[SLOPE_W-1:0];
                REG_END_SLOPE:   es_reg <= cfg_data[SLOPE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        h_diff = $signed({s1_reg[DATA_WIDTH-1], s1_reg}) - $signed({s0_reg[DATA_WIDTH-1], s0_reg});
        c_mag  = cs_reg[SLOPE_W-1] ? (~cs_reg + SLOPE_W'(1)) : cs_reg;
        e_mag  = es_reg[SLOPE_W-1] ? (~es_reg + SLOPE_W'(1)) : es_reg;
        c_sum  = (CPROD_W+1)'(cprod_reg) + ((CPROD_W+1)'(1) << (FRAC_BITS - 1));
        e_sum  = (CPROD_W+1)'(eprod_reg) + ((CPROD_W+1)'(1) << (FRAC_BITS - 1));
        c_rnd  = c_sum[CPROD_W:FRAC_BITS];
        e_rnd  = e_sum[CPROD_W:FRAC_BITS];
        x0_ext = acc_t'($signed(x0_reg));
        x1_ext = acc_t'($signed(x1_reg));
    end

    // The derived constants are registered after a write: h and the bad
    // flag, then the slope products, then C and E, then A and B.
    always_ff @(posedge clk)
    begin
        h_reg     <= h_diff[H_W-1:0];
        bad_reg   <= (h_diff <= 0);
        cprod_reg <= c_mag * h_reg;
        eprod_reg <= e_mag * h_reg;
        cneg_reg  <= cs_reg[SLOPE_W-1];
        eneg_reg  <= es_reg[SLOPE_W-1];
        c_val_reg <= cneg_reg ? -acc_t'(c_rnd) : acc_t'(c_rnd);
        e_val_reg <= eneg_reg ? -acc_t'(e_rnd) : acc_t'(e_rnd);
        a_reg     <= e_val_reg - x1_ext * 2 + c_val_reg + x0_ext * 2;
        b_reg     <= x1_ext * 3 - e_val_reg - c_val_reg * 2 - x0_ext * 3;
    end

    assign coef.s0  = s0_reg;
    assign coef.h   = h_reg;
    assign coef.bad = bad_reg;
    assign coef.a   = a_reg;
    assign coef.b   = b_reg;
    assign coef.c   = c_val_reg;
    assign coef.x0  = x0_ext;

endmodule

>>> rtl/che_div.sv
// Pipelined restoring divider that forms the normalized position u.
module che_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_valid,
    input  logic [che_pkg::DATA_WIDTH-1:0]  sample_position,
    input  logic [che_pkg::DATA_WIDTH-1:0]  seg_start,
    input  logic [che_pkg::H_W-1:0]         h,
    output logic                            u_valid,
    output che_pkg::u_t                     u
);
    import che_pkg::*;

    logic signed [DATA_WIDTH:0] ds;
    logic [DATA_WIDTH:0]        ds_abs;
    logic [H_W:0]               trial   [0:Q_W-1];
    logic [H_W:0]               diff    [0:Q_W-1];
    logic [H_W-1:0]             rem_nx  [0:Q_W-1];
    logic                       qbit    [0:Q_W-1];
    logic [Q_W-1:0]             nq_reg  [0:Q_W];
    logic [H_W-1:0]             rem_reg [0:Q_W];
    logic                       neg_reg [0:Q_W];
    logic                       vld_reg [0:Q_W];
    logic [Q_W:0]               q_inc;
    logic [Q_W-1:0]             u_mag;
    logic                       u_valid_reg;
    u_t                         u_reg;

    always_comb
    begin
        ds     = $signed({sample_position[DATA_WIDTH-1], sample_position})
               - $signed({seg_start[DATA_WIDTH-1], seg_start});
        ds_abs = ds[DATA_WIDTH] ? -ds : ds;
        for (int k = 0; k < Q_W; k++)
        begin
            trial[k]  = {rem_reg[k], nq_reg[k][Q_W-1]};
            diff[k]   = trial[k] - {1'b0, h};
            qbit[k]   = (trial[k] >= {1'b0, h});
            rem_nx[k] = qbit[k] ? diff[k][H_W-1:0] : trial[k][H_W-1:0];
        end
        q_inc = {1'b0, nq_reg[Q_W]} + (Q_W+1)'(1);
        u_mag = q_inc[Q_W:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= Q_W; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            u_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 0; k < Q_W; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
            u_valid_reg <= vld_reg[Q_W];
        end
    end

    // The numerator shifts out of the top while quotient bits shift in below.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nq_reg[0]  <= {ds_abs[DATA_WIDTH-1:0], (FRAC_BITS+1)'(0)};
            rem_reg[0] <= '0;
            neg_reg[0] <= ds[DATA_WIDTH];
            for (int k = 0; k < Q_W; k++)
            begin
                nq_reg[k+1]  <= {nq_reg[k][Q_W-2:0], qbit[k]};
                rem_reg[k+1] <= rem_nx[k];
                neg_reg[k+1] <= neg_reg[k];
            end
            u_reg <= neg_reg[Q_W] ? -$signed({1'b0, u_mag}) : $signed({1'b0, u_mag});
        end
    end

    assign u_valid = u_valid_reg;
    assign u       = u_reg;

endmodule

>>> rtl/che_mac.sv
// One Horner step: rounded, limited product with u plus a coefficient.
module che_mac (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  che_pkg::mac_data_t   in_data,
    input  che_pkg::acc_t        addend,
    output logic                 out_valid,
    output che_pkg::mac_data_t   out_data
);
    import che_pkg::*;

    logic [ACC_W-1:0]         p_mag_reg;
    logic [U_W-1:0]           u_mag_reg;
    logic                     neg_a_reg;
    mac_data_t                d_a_reg;
    logic                     v_a_reg;

    logic [2*PART_W-1:0]          pp00_reg;
    logic [PART_W+U_HI_W-1:0]     pp01_reg;
    logic [ACC_HI_W+PART_W-1:0]   pp10_reg;
    logic [ACC_HI_W+U_HI_W-1:0]   pp11_reg;
    logic                     neg_b_reg;
    mac_data_t                d_b_reg;
    logic                     v_b_reg;

    logic [P_W:0]             sum;
    logic [RND_W-1:0]         rnd_reg;
    logic                     neg_c_reg;
    mac_data_t                d_c_reg;
    logic                     v_c_reg;

    logic                     lim;
    logic [ACC_W-1:0]         mag;
    mac_data_t                d_d_reg;
    logic                     v_d_reg;

    always_comb
    begin
        sum = (P_W+1)'(pp00_reg)
            + ((P_W+1)'(pp01_reg) << PART_W)
            + ((P_W+1)'(pp10_reg) << PART_W)
            + ((P_W+1)'(pp11_reg) << (2 * PART_W))
            + ((P_W+1)'(1) << (FRAC_BITS - 1));
        lim = (rnd_reg > RND_W'(LIMIT_MAG));
        mag = lim ? LIMIT_MAG : rnd_reg[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_a_reg <= in_valid;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
            v_d_reg <= v_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_mag_reg <= in_data.acc[ACC_W-1] ? -in_data.acc : in_data.acc;
            u_mag_reg <= in_data.u[U_W-1] ? -in_data.u : in_data.u;
            neg_a_reg <= in_data.acc[ACC_W-1] ^ in_data.u[U_W-1];
            d_a_reg   <= in_data;

            pp00_reg  <= p_mag_reg[PART_W-1:0] * u_mag_reg[PART_W-1:0];
            pp01_reg  <= p_mag_reg[PART_W-1:0] * u_mag_reg[U_W-1:PART_W];
            pp10_reg  <= p_mag_reg[ACC_W-1:PART_W] * u_mag_reg[PART_W-1:0];
            pp11_reg  <= p_mag_reg[ACC_W-1:PART_W] * u_mag_reg[U_W-1:PART_W];
            neg_b_reg <= neg_a_reg;
            d_b_reg   <= d_a_reg;

            rnd_reg   <= sum[P_W:FRAC_BITS];
            neg_c_reg <= neg_b_reg;
            d_c_reg   <= d_b_reg;

            d_d_reg.u   <= d_c_reg.u;
            d_d_reg.sat <= d_c_reg.sat | lim;
            d_d_reg.acc <= neg_c_reg ? addend - acc_t'(mag) : addend + acc_t'(mag);
        end
    end

    assign out_valid = v_d_reg;
    assign out_data  = d_d_reg;

endmodule

>>> rtl/cubic_hermite_segment_eval.sv
// Top level of the fixed-point cubic Hermite segment evaluator.
//
// Usage: write the six segment registers through cfg_wr_en, cfg_index and
// cfg_data while no item is in flight. Each item on the input channel
// (in_valid/in_ready) carries one sample position in signed Q16.16, and each
// item on the output channel (out_valid/out_ready) carries the interpolated
// value with its overflow and bad_segment flags, in the order of the inputs.
// The block takes one item per cycle while the output is not blocked. The
// stages are one input stage, 49 divider stages (one quotient bit per
// stage, set by the quotient width), one stage to round u, three Horner
// steps of four stages each, and the output register.
// Reset clears all valid bits and loads the register reset values; the
// block accepts items in the first cycle after reset.
// The whole pipeline advances together: when the output register holds an
// item that the receiver does not take, in_ready drops and every stage holds,
// so nothing is lost or repeated.
`include "cubic_hermite_segment_eval_assert.svh"

module cubic_hermite_segment_eval (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [che_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [che_pkg::DATA_WIDTH-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [che_pkg::DATA_WIDTH-1:0]  sample_position,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [che_pkg::DATA_WIDTH-1:0]  value,
    output logic                                   overflow,
    output logic                                   bad_segment
);
    import che_pkg::*;

    coef_t     coef;
    logic      adv;
    logic      u_valid;
    u_t        u;
    mac_data_t m0_data;
    mac_data_t m1_data;
    mac_data_t m2_data;
    mac_data_t m3_data;
    logic      m1_valid;
    logic      m2_valid;
    logic      m3_valid;

    logic signed [DATA_WIDTH-1:0] value_next;
    logic                         overflow_next;
    logic signed [DATA_WIDTH-1:0] value_reg;
    logic                         overflow_reg;
    logic                         bad_segment_reg;
    logic                         out_valid_reg;

    // A single advance signal moves every stage; it is low only while the
    // output register holds an item the receiver has not yet taken.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    che_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // The divider forms u = round(ds * 2^F / h) with ds = position - start.
    che_div u_div (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (in_valid),
        .sample_position (sample_position),
        .seg_start       (coef.s0),
        .h               (coef.h),
        .u_valid         (u_valid),
        .u               (u)
    );

    // Horner's rule: acc = A, then acc*u + B, acc*u + C, acc*u + x0.
    assign m0_data.sat = 1'b0;
    assign m0_data.acc = coef.a;
    assign m0_data.u   = u;

    che_mac u_mac_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (u_valid),
        .in_data   (m0_data),
        .addend    (coef.b),
        .out_valid (m1_valid),
        .out_data  (m1_data)
    );

    che_mac u_mac_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (m1_valid),
        .in_data   (m1_data),
        .addend    (coef.c),
        .out_valid (m2_valid),
        .out_data  (m2_data)
    );

    che_mac u_mac_x0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (m2_valid),
        .in_data   (m2_data),
        .addend    (coef.x0),
        .out_valid (m3_valid),
        .out_data  (m3_data)
    );

    // A bad segment returns the start value unchanged. An internal limit hit
    // saturates toward the sign of the final accumulator; otherwise the
    // accumulator is clamped to the output range.
    always_comb
    begin
        overflow_next = 1'b0;
        value_next    = m3_data.acc[DATA_WIDTH-1:0];
        if (coef.bad)
        begin
            value_next = coef.x0[DATA_WIDTH-1:0];
        end
        else if (m3_data.sat)
        begin
            overflow_next = 1'b1;
            value_next    = m3_data.acc[ACC_W-1] ? VAL_MIN[DATA_WIDTH-1:0]
                                                 : VAL_MAX[DATA_WIDTH-1:0];
        end
        else if (m3_data.acc > VAL_MAX)
        begin
            overflow_next = 1'b1;
            value_next    = VAL_MAX[DATA_WIDTH-1:0];
        end
        else if (m3_data.acc < VAL_MIN)
        begin
            overflow_next = 1'b1;
            value_next    = VAL_MIN[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= m3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg       <= value_next;
            overflow_reg    <= overflow_next;
            bad_segment_reg <= coef.bad;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign overflow    = overflow_reg;
    assign bad_segment = bad_segment_reg;

    // A bad segment never reports overflow.
    `CHE_ASSERT_IMPLY(a_bad_no_ovf, clk, rst_n, out_valid_reg && bad_segment_reg, !overflow_reg)
    // An overflowed item always sits on one of the output rails.
    `CHE_ASSERT_IMPLY(a_ovf_rail, clk, rst_n, out_valid_reg && overflow_reg, value_reg == VAL_MAX[DATA_WIDTH-1:0] || value_reg == VAL_MIN[DATA_WIDTH-1:0])
    // While the output is blocked the last Horner stage holds its item.
    `CHE_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(m3_valid))

endmodule

>>> tb/tb_cubic_hermite_segment_eval.sv
// Self-checking testbench for the cubic Hermite segment evaluator.
`timescale 1ns / 1ps

module tb_cubic_hermite_segment_eval;
    import che_pkg::*;

    // Pipeline latency of the block; drain waits longer than this.
    localparam int PIPE_LATENCY  = 63;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 10;
    // Cycles with no accepted item before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 20000;
    // Length of the long receiver hold-off used to fill the pipeline.
    localparam int HOLD_OFF_CYCLES = 300;

    // Register indexes the block does not decode; writes to them are ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam longint VALUE_MAX = 64'sd2147483647;
    localparam longint VALUE_MIN = -64'sd2147483648;

    // One expected evaluation result.
    typedef struct {
        logic [DATA_WIDTH-1:0] value;
        logic                  overflow;
        logic                  bad_segment;
    } sample_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [DATA_WIDTH-1:0]         cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [DATA_WIDTH-1:0]  sample_position;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [DATA_WIDTH-1:0]  value;
    logic                          overflow;
    logic                          bad_segment;

    // Shadow copy of the segment registers, updated on every write.
    logic signed [DATA_WIDTH-1:0]  seg_start_q;
    logic signed [DATA_WIDTH-1:0]  seg_end_q;
    logic signed [DATA_WIDTH-1:0]  start_value_q;
    logic signed [DATA_WIDTH-1:0]  end_value_q;
    logic signed [SLOPE_W-1:0]     start_slope_q;
    logic signed [SLOPE_W-1:0]     end_slope_q;

    sample_result_t expected_samples[$];
    int  mismatch_count;
    int  burst_left;
    int  stall_mode;
    bit  hold_request;
    int  hold_left;
    int  idle_cycles;

    cubic_hermite_segment_eval u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample_position (sample_position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .value           (value),
        .overflow        (overflow),
        .bad_segment     (bad_segment)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] magnitude_of(longint v);
        logic [63:0] m;
        m = v;
        if (v < 0)
        begin
            m = -m;
        end
        return m;
    endfunction

    // Product of two fixed-point numbers, shifted down by the fraction width
    // with rounding half away from zero, and clipped at the internal limit.
    function automatic longint fixed_product(longint a, longint b, inout bit sat);
        logic [127:0] p;
        logic [63:0]  m;
        bit           neg;
        neg = (a < 0) != (b < 0);
        p = {64'd0, magnitude_of(a)} * {64'd0, magnitude_of(b)};
        p = (p + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (p > {64'd0, LIMIT_MAG})
        begin
            sat = 1'b1;
            m = LIMIT_MAG;
        end
        else
        begin
            m = p[63:0];
        end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Offset into the segment divided by its length, as a fixed-point
    // fraction rounded to nearest; very large quotients clip to the limit.
    function automatic longint segment_fraction(longint ds, longint h, inout bit sat);
        logic [63:0] md;
        logic [63:0] hu;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] frac;
        logic [63:0] m;
        md = magnitude_of(ds);
        hu = h;
        q = md / hu;
        r = md % hu;
        if (q > (LIMIT_MAG >> FRAC_BITS))
        begin
            sat = 1'b1;
            m = LIMIT_MAG;
        end
        else
        begin
            frac = (r << (FRAC_BITS + 1)) / hu;
            m = (q << FRAC_BITS) + ((frac + 64'd1) >> 1);
        end
        return ds < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic sample_result_t evaluate_segment(logic signed [DATA_WIDTH-1:0] pos);
        sample_result_t res;
        longint h;
        longint ds;
        longint x0;
        longint x1;
        longint cc;
        longint ee;
        longint coef_a;
        longint coef_b;
        longint u;
        longint acc;
        bit     sat;
        sat = 1'b0;
        res.overflow = 1'b0;
        res.bad_segment = 1'b0;
        x0 = start_value_q;
        x1 = end_value_q;
        h = longint'(seg_end_q) - longint'(seg_start_q);
        if (h <= 0)
        begin
            res.value = start_value_q;
            res.bad_segment = 1'b1;
            return res;
        end
        ds = longint'(pos) - longint'(seg_start_q);
        cc = fixed_product(longint'(start_slope_q), h, sat);
        ee = fixed_product(longint'(end_slope_q), h, sat);
        coef_a = ee - 2 * x1 + cc + 2 * x0;
        coef_b = 3 * x1 - ee - 2 * cc - 3 * x0;
        u = segment_fraction(ds, h, sat);
        // Horner's rule in the normalized coordinate.
        acc = coef_a;
        acc = fixed_product(acc, u, sat) + coef_b;
        acc = fixed_product(acc, u, sat) + cc;
        acc = fixed_product(acc, u, sat) + x0;
        if (sat)
        begin
            res.overflow = 1'b1;
            acc = (acc < 0) ? VALUE_MIN : VALUE_MAX;
        end
        else if (acc > VALUE_MAX)
        begin
            res.overflow = 1'b1;
            acc = VALUE_MAX;
        end
        else if (acc < VALUE_MIN)
        begin
            res.overflow = 1'b1;
            acc = VALUE_MIN;
        end
        res.value = acc[DATA_WIDTH-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Appends one expectation at the tail of the scoreboard queue.
    task automatic record_expected(sample_result_t res);
        expected_samples = {expected_samples, res};
    endtask

    // Writes one register and mirrors it in the shadow copy. The write
    // enable stays high; end_config lowers it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_WIDTH-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_SEG_START:   seg_start_q   = data;
            REG_SEG_END:     seg_end_q     = data;
            REG_START_VALUE: start_value_q = data;
            REG_END_VALUE:   end_value_q   = data;
            REG_START_SLOPE: start_slope_q = data[SLOPE_W-1:0];
            REG_END_SLOPE:   end_slope_q   = data[SLOPE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_config();
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_segment(logic [31:0] s0, logic [31:0] s1, logic [31:0] x0,
                                logic [31:0] x1, logic [31:0] c, logic [31:0] e);
        write_reg(REG_SEG_START, s0);
        write_reg(REG_SEG_END, s1);
        write_reg(REG_START_VALUE, x0);
        write_reg(REG_END_VALUE, x1);
        write_reg(REG_START_SLOPE, c);
        write_reg(REG_END_SLOPE, e);
        end_config();
    endtask

    // Sends one sample position. The sender works in bursts; at the start of
    // each burst it may drop valid for a random gap. Valid stays high
    // between back-to-back items, so it is never lowered and raised in the
    // same step. The expectation is recorded at the accepting edge.
    task automatic send_position(logic [DATA_WIDTH-1:0] pos);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid        <= 1'b1;
        sample_position <= pos;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        record_expected(evaluate_segment(pos));
    endtask

    // Lowers valid, waits for every expected result, then lets the
    // pipeline settle so that register writes happen while it is empty.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sample position mostly inside or near the segment, sometimes anywhere.
    function automatic logic [31:0] pick_position();
        longint h;
        h = longint'(seg_end_q) - longint'(seg_start_q);
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return seg_start_q + $signed($urandom_range(0, 8)) - 4;
            3:       return seg_end_q + $signed($urandom_range(0, 8)) - 4;
            default:
            begin
                if (h > 0 && h < 64'sd4294967295)
                begin
                    return seg_start_q + 32'(($urandom() % (h + 1)));
                end
                return $urandom();
            end
        endcase
    endfunction

    // Random segment; lengths span one LSB up to the full range, with most
    // of them moderate. Slope data carries random junk in the unused bits.
    task automatic load_random_segment();
        logic [31:0] s0;
        logic [31:0] h;
        logic [31:0] x0;
        logic [31:0] x1;
        case ($urandom_range(0, 7))
            0:       h = $urandom_range(1, 16);
            1:       h = $urandom();
            2:       h = 32'($urandom_range(1, 64)) << FRAC_BITS;
            default: h = $urandom_range(1, 32'h0010_0000);
        endcase
        s0 = ($urandom_range(0, 3) == 0) ? $urandom()
           : 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        x0 = ($urandom_range(0, 3) == 0) ? $urandom()
           : 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
        x1 = ($urandom_range(0, 3) == 0) ? $urandom()
           : 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
        load_segment(s0, s0 + h, x0, x1, $urandom(), $urandom());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: unit segment from 0 to 1.0, all values and slopes zero.
    task automatic test_reset_segment();
        send_position(32'h0000_0000);
        send_position(32'h0001_0000);
        send_position(32'h0000_8000);
        send_position(32'h7FFF_FFFF);
        send_position(32'h8000_0000);
        drain_pipeline();
    endtask

    // Hand-picked segments: endpoints, midpoint, far extrapolation that
    // saturates, a zero-length and a reversed segment, the slope extremes,
    // the unused slope bits and writes to undecoded indexes.
    task automatic test_directed_segments();
        load_segment(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000,
                     32'h0001_0000, 32'h0003_0000);
        send_position(32'h0000_0000);
        send_position(32'h0001_0000);
        send_position(32'h0000_8000);
        send_position(32'h7FFF_FFFF);
        send_position(32'h8000_0000);
        drain_pipeline();

        // Zero-length segment and fully reversed segment.
        load_segment(32'h0000_1000, 32'h0000_1000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h0001_0000, 32'h0001_0000);
        send_position(32'h0000_1000);
        drain_pipeline();
        write_reg(REG_SEG_START, 32'h7FFF_FFFF);
        write_reg(REG_SEG_END, 32'h8000_0000);
        end_config();
        send_position(32'h1234_5678);
        drain_pipeline();

        // Full-range segment with extreme values and slopes; the upper
        // slope data bits are set and must be ignored.
        load_segment(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hFFFF_0000 | 32'h0001_0000, 32'h0002_0000 | 32'hABCC_0000);
        send_position(32'h8000_0000);
        send_position(32'h7FFF_FFFF);
        send_position(32'h0000_0000);
        drain_pipeline();

        // One-LSB segment: tiny h gives huge normalized positions.
        load_segment(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'h0001_0000,
                     32'h0001_FFFF, 32'h0002_0000);
        send_position(32'h0000_0001);
        send_position(32'h0000_0002);
        send_position(32'hFFFF_FFFF);
        send_position(32'h7FFF_FFFF);
        drain_pipeline();

        // Undecoded indexes leave the registers as they are.
        write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_7, 32'h0000_0000);
        end_config();
        send_position(32'h0000_0001);
        send_position(32'h0000_0000);
        drain_pipeline();
    endtask

    // Random segments with random positions, under several receiver stall
    // patterns.
    task automatic test_random_segments();
        int phase;
        int n;
        for (phase = 0; phase < 12; phase++)
        begin
            stall_mode = phase % 3;
            load_random_segment();
            for (n = 0; n < 45; n++)
            begin
                send_position(pick_position());
            end
            drain_pipeline();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items, so the pipeline fills and the input stalls. Then the
    // sender pauses until every result is back.
    task automatic test_backpressure();
        int n;
        stall_mode = 0;
        load_random_segment();
        hold_request = 1'b1;
        for (n = 0; n < 120; n++)
        begin
            send_position(pick_position());
        end
        drain_pipeline();
        stall_mode = 1;
        for (n = 0; n < 30; n++)
        begin
            send_position(pick_position());
        end
        drain_pipeline();
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Stall patterns: always ready, random stalls, and a fixed rhythm. A
    // hold-off request overrides them for a long stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left <= HOLD_OFF_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ((int'($realtime / 10.0) % 7) < 4);
            endcase
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        sample_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value=%h", value));
            end
            else
            begin
                exp_res = expected_samples.pop_front();
                if (value !== exp_res.value)
                begin
                    report_mismatch($sformatf("value %h, expected %h", value, exp_res.value));
                end
                if (overflow !== exp_res.overflow)
                begin
                    report_mismatch($sformatf("overflow %b, expected %b", overflow,
                                              exp_res.overflow));
                end
                if (bad_segment !== exp_res.bad_segment)
                begin
                    report_mismatch($sformatf("bad_segment %b, expected %b", bad_segment,
                                              exp_res.bad_segment));
                end
            end
        end
    end

    // Counts cycles in which nothing is accepted on any port.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_SEG_START;
        cfg_data        = '0;
        in_valid        = 1'b0;
        sample_position = '0;
        mismatch_count  = 0;
        burst_left      = 0;
        stall_mode      = 0;
        hold_request    = 1'b0;
        idle_cycles     = 0;
        seg_start_q     = '0;
        seg_end_q       = SEG_END_RESET;
        start_value_q   = '0;
        end_value_q     = '0;
        start_slope_q   = '0;
        end_slope_q     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_segment();
        test_directed_segments();
        test_random_segments();
        test_backpressure();

        if (mismatch_count == 0 && expected_samples.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
